// ----- design/sdar_pkg.sv -----
package sdar_pkg;

  // default widths of the sample and time fields
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 16;

  // configuration register widths
  localparam int unsigned DEADZONE_W = 15;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEADZONE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REPEAT_INTERVAL = 2'd2;

  // configuration reset values
  localparam logic [DEADZONE_W-1:0] DEADZONE_RST        = 15'd8192;
  localparam logic [DELAY_W-1:0]    FIRST_DELAY_RST     = 16'd300;
  localparam logic [DELAY_W-1:0]    REPEAT_INTERVAL_RST = 16'd100;

  localparam int unsigned MOVE_W = 3;

  typedef enum logic [MOVE_W-1:0] {
    MOVE_NONE  = 3'd0,
    MOVE_RIGHT = 3'd1,
    MOVE_LEFT  = 3'd2,
    MOVE_UP    = 3'd3,
    MOVE_DOWN  = 3'd4
  } move_e;

  typedef struct packed {
    logic [DEADZONE_W-1:0] deadzone;
    logic [DELAY_W-1:0]    first_delay;
    logic [DELAY_W-1:0]    repeat_interval;
  } cfg_t;

endpackage

// ----- design/sdar_if.sv -----
interface sdar_in_if #(
  parameter int unsigned SAMPLE_BITS = sdar_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = sdar_pkg::TIME_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] stick_x;
  logic signed [SAMPLE_BITS-1:0] stick_y;
  logic        [TIME_BITS-1:0]   elapsed;

  modport source (output valid, output stick_x, output stick_y, output elapsed,
                  input ready);
  modport sink (input valid, input stick_x, input stick_y, input elapsed,
                output ready);
endinterface

interface sdar_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdar_pkg::MOVE_W-1:0]   move;

  modport source (output valid, output move, input ready);
  modport sink (input valid, input move, output ready);
endinterface

// ----- design/sdar_dir_pick.sv -----
module sdar_dir_pick #(
  parameter int unsigned SAMPLE_BITS = sdar_pkg::SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0]          stick_x_i,
  input  logic signed [SAMPLE_BITS-1:0]          stick_y_i,
  input  logic        [sdar_pkg::DEADZONE_W-1:0] deadzone_i,
  output sdar_pkg::move_e                        dir_o
);

  localparam int unsigned MAG_W =
    (SAMPLE_BITS > sdar_pkg::DEADZONE_W) ? SAMPLE_BITS : sdar_pkg::DEADZONE_W;

  logic [SAMPLE_BITS-1:0] mag_x, mag_y;
  logic [MAG_W-1:0]       mag_x_ext, mag_y_ext, dz_ext;
  logic                   x_pos, y_pos;

  // magnitude of the most negative value wraps to 2^(n-1) as unsigned
  assign mag_x = stick_x_i[SAMPLE_BITS-1] ? (~stick_x_i + 1'b1) : stick_x_i;
  assign mag_y = stick_y_i[SAMPLE_BITS-1] ? (~stick_y_i + 1'b1) : stick_y_i;

  assign mag_x_ext = MAG_W'(mag_x);
  assign mag_y_ext = MAG_W'(mag_y);
  assign dz_ext    = MAG_W'(deadzone_i);

  assign x_pos = !stick_x_i[SAMPLE_BITS-1] && (stick_x_i != '0);
  assign y_pos = !stick_y_i[SAMPLE_BITS-1] && (stick_y_i != '0);

  always_comb begin
    if ((mag_x_ext < dz_ext) && (mag_y_ext < dz_ext)) begin
      dir_o = sdar_pkg::MOVE_NONE;
    end else if (mag_x >= mag_y) begin
      dir_o = x_pos ? sdar_pkg::MOVE_RIGHT : sdar_pkg::MOVE_LEFT;
    end else begin
      dir_o = y_pos ? sdar_pkg::MOVE_UP : sdar_pkg::MOVE_DOWN;
    end
  end

endmodule

// ----- design/sdar_rpt_timer.sv -----
module sdar_rpt_timer #(
  parameter int unsigned TIME_BITS = sdar_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  sdar_pkg::move_e      dir_i,
  input  logic [TIME_BITS-1:0] elapsed_i,
  input  sdar_pkg::cfg_t       cfg_i,
  output sdar_pkg::move_e      move_o
);

  // countdown spans +-(2^w - 1) of the wider of time and delay fields
  localparam int unsigned CNT_W =
    ((TIME_BITS > sdar_pkg::DELAY_W) ? TIME_BITS : sdar_pkg::DELAY_W) + 2;

  sdar_pkg::move_e         held_q, held_d;
  logic signed [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [CNT_W-1:0] dt_ext, fd_ext, ri_ext, dec, sum;

  assign dt_ext = $signed({{(CNT_W-TIME_BITS){1'b0}}, elapsed_i});
  assign fd_ext = $signed({{(CNT_W-sdar_pkg::DELAY_W){1'b0}}, cfg_i.first_delay});
  assign ri_ext = $signed({{(CNT_W-sdar_pkg::DELAY_W){1'b0}}, cfg_i.repeat_interval});
  assign dec    = cnt_q - dt_ext;
  assign sum    = dec + ri_ext;

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    move_o = sdar_pkg::MOVE_NONE;
    if (dir_i == sdar_pkg::MOVE_NONE) begin
      held_d = sdar_pkg::MOVE_NONE;
      cnt_d  = '0;
    end else if (dir_i != held_q) begin
      held_d = dir_i;
      cnt_d  = fd_ext;
      move_o = dir_i;
    end else if (dec > 0) begin
      cnt_d = dec;
    end else begin
      // overshoot carries over, a long stall reloads the full interval
      cnt_d  = (sum < 0) ? ri_ext : sum;
      move_o = dir_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= sdar_pkg::MOVE_NONE;
      cnt_q  <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- design/stick_direction_auto_repeat.sv -----
// channel    | dir | payload                               | handshake
// -----------+-----+---------------------------------------+------------
// sample_i   | in  | stick_x, stick_y (signed), elapsed    | valid/ready
// move_o     | out | move (0 none, 1 right, 2 left, 3 up,  | valid/ready
//            |     | 4 down), one word per sample word     |
// cfg        | in  | cfg_we_i, cfg_idx_i, cfg_data_i       | write only
//
// one sample word per clock while move_o does not stall; the move word passes
// the input register, then the direction pick and countdown update feeding the
// result register. rst_ni clears the held direction, the countdown,
// the valid flags and restores the configuration defaults. a stall on move_o
// backs up through the two registers; each stage accepts as soon as its
// contents move on, so no bubble is inserted under continuous flow
module stick_direction_auto_repeat #(
  parameter int unsigned SAMPLE_BITS = sdar_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = sdar_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdar_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sdar_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sdar_in_if.sink                            sample_i,
  sdar_out_if.source                         move_o
);

  // configuration registers
  sdar_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone        <= sdar_pkg::DEADZONE_RST;
      cfg_q.first_delay     <= sdar_pkg::FIRST_DELAY_RST;
      cfg_q.repeat_interval <= sdar_pkg::REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdar_pkg::CFG_IDX_DEADZONE:
          cfg_q.deadzone <= cfg_data_i[sdar_pkg::DEADZONE_W-1:0];
        sdar_pkg::CFG_IDX_FIRST_DELAY:
          cfg_q.first_delay <= cfg_data_i[sdar_pkg::DELAY_W-1:0];
        sdar_pkg::CFG_IDX_REPEAT_INTERVAL:
          cfg_q.repeat_interval <= cfg_data_i[sdar_pkg::DELAY_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // stage 1: input register
  logic                          in_vld_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic        [TIME_BITS-1:0]   dt_q;

  // stage 2: result register
  logic                          out_vld_q;
  sdar_pkg::move_e               move_q, move_d;

  logic                          out_free;  // result register can take a word
  logic                          step;      // stage 1 word moves to the result
  logic                          in_take;   // sample word accepted
  sdar_pkg::move_e               dir;

  assign out_free       = !out_vld_q || move_o.ready;
  assign step           = in_vld_q && out_free;
  assign sample_i.ready = !in_vld_q || out_free;
  assign in_take        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q  <= sample_i.stick_x;
      y_q  <= sample_i.stick_y;
      dt_q <= sample_i.elapsed;
    end
  end

  // dominant axis and sign, deadzone check
  sdar_dir_pick #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dir_pick (
    .stick_x_i (x_q),
    .stick_y_i (y_q),
    .deadzone_i(cfg_q.deadzone),
    .dir_o     (dir)
  );

  // held direction and countdown; state advances only when the word moves on
  sdar_rpt_timer #(
    .TIME_BITS(TIME_BITS)
  ) u_rpt_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .dir_i    (dir),
    .elapsed_i(dt_q),
    .cfg_i    (cfg_q),
    .move_o   (move_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      move_q <= move_d;
    end
  end

  assign move_o.valid = out_vld_q;
  assign move_o.move  = move_q;

endmodule
